FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/swr_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window RMS package
// Fixed result width and the control state encoding.
// ---------------------------------------------------------------------------
package swr_pkg;

    localparam int RMS_W = 16;

    typedef logic [RMS_W-1:0] rms_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_ACC  = 6'b000100,
        S_DIV  = 6'b001000,
        S_SQRT = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

endpackage

FILE: src/swr_ifs.sv
// ---------------------------------------------------------------------------
// Sliding window RMS stream interfaces
// Valid/ready channels for incoming samples and outgoing RMS results.
// ---------------------------------------------------------------------------
interface swr_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swr_rms_if;
    import swr_pkg::*;

    logic valid;
    logic ready;
    rms_t rms_value;

    modport source (output valid, output rms_value, input ready);
    modport sink   (input valid, input rms_value, output ready);
endinterface

FILE: src/sliding_window_rms.sv
// ---------------------------------------------------------------------------
// Sliding window RMS
// Exact integer true RMS over the most recent window_size samples.
// ---------------------------------------------------------------------------
// Each accepted sample beat yields one result beat equal to
// floor(sqrt(floor(sum of squares / fill count))) over the filled part of the
// window. Samples live in a single-port store of MAX_WINDOW entries with a
// registered read; the oldest sample is read back, squared and subtracted
// from the running sum once the window is full. One sample is processed at
// a time: the serial restoring divider needs one cycle per bit of the padded
// sum and the serial square root one cycle per result bit. The result sits
// in an output register, so the next sample is accepted while a result is
// still waiting. Writing window_size clamps it to the range one to MAX_WINDOW
// and empties the window.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_rms #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    swr_sample_if.sink                           samples,
    swr_rms_if.source                            results,
    input  logic                                 cfg_wr_en,
    input  logic [$clog2(MAX_WINDOW + 1) - 1:0]  cfg_wr_data
);
    import swr_pkg::*;

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int SQ_BITS = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_BITS + $clog2(MAX_WINDOW);
    localparam int SQ_W   = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int CNT_W  = $clog2(RAD_W + 1);

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    state_t                        state_reg, state_next;
    logic [WIN_W-1:0]              window_reg, window_next;
    logic [WIN_W-1:0]              fill_reg, fill_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [SQ_BITS-1:0]            old_sq_reg, new_sq_reg;
    logic [RAD_W-1:0]              work_reg, work_next;
    logic [WIN_W-1:0]              div_rem_reg, div_rem_next;
    logic [SQ_W:0]                 sq_rem_reg, sq_rem_next;
    logic [SQ_W-1:0]               root_reg, root_next;
    rms_t                          out_data_reg, out_data_next;

    logic                          accept;
    logic                          full;
    logic [WIN_W-1:0]              cfg_clamped;
    logic [WIN_W-1:0]              idx_inc;
    logic signed [2*SAMPLE_BITS-1:0] old_prod, new_prod;
    logic [WIN_W:0]                div_shift;
    logic                          div_ge;
    logic [SQ_W+2:0]               sq_shift;
    logic [SQ_W+2:0]               sq_trial;
    logic                          sq_ge;

    assign accept         = samples.valid && samples.ready;
    assign samples.ready  = (state_reg == S_IDLE);
    assign results.valid  = out_valid_reg;
    assign results.rms_value = out_data_reg;

    assign full     = (fill_reg >= window_reg);
    assign idx_inc  = WIN_W'(idx_reg) + WIN_W'(1);
    assign old_prod = old_reg * old_reg;
    assign new_prod = sample_reg * sample_reg;

    assign div_shift = {div_rem_reg, work_reg[RAD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, fill_reg});

    assign sq_shift = {sq_rem_reg, work_reg[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_clamped = WIN_W'(1);
        end
        else if (cfg_wr_data > WIN_W'(MAX_WINDOW))
        begin
            cfg_clamped = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_clamped = cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        work_next      = work_reg;
        div_rem_next   = div_rem_reg;
        sq_rem_next    = sq_rem_reg;
        root_next      = root_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (full)
                begin
                    sum_next = sum_reg + SUM_W'(new_sq_reg) - SUM_W'(old_sq_reg);
                end
                else
                begin
                    sum_next  = sum_reg + SUM_W'(new_sq_reg);
                    fill_next = fill_reg + WIN_W'(1);
                end
                idx_next     = (idx_inc == window_reg) ? '0 : idx_inc[IDX_W-1:0];
                work_next    = RAD_W'(sum_next);
                div_rem_next = '0;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                div_rem_next = div_ge ? WIN_W'(div_shift - {1'b0, fill_reg})
                                      : div_shift[WIN_W-1:0];
                work_next    = {work_reg[RAD_W-2:0], div_ge};
                if (cnt_reg == CNT_W'(RAD_W - 1))
                begin
                    cnt_next    = '0;
                    sq_rem_next = '0;
                    root_next   = '0;
                    state_next  = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SQRT:
            begin
                sq_rem_next = sq_ge ? (SQ_W+1)'(sq_shift - sq_trial)
                                    : sq_shift[SQ_W:0];
                root_next   = {root_reg[SQ_W-2:0], sq_ge};
                work_next   = {work_reg[RAD_W-3:0], 2'b00};
                if (cnt_reg == CNT_W'(SQ_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_HOLD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_data_next  = RMS_W'(root_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            window_next = cfg_clamped;
            fill_next   = '0;
            idx_next    = '0;
            sum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WIN_W'(MAX_WINDOW);
            fill_reg      <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        div_rem_reg  <= div_rem_next;
        sq_rem_reg   <= sq_rem_next;
        root_reg     <= root_next;
        out_data_reg <= out_data_next;
        if (accept)
        begin
            sample_reg <= samples.sample;
        end
        if (state_reg == S_READ)
        begin
            old_sq_reg <= old_prod[SQ_BITS-1:0];
            new_sq_reg <= new_prod[SQ_BITS-1:0];
        end
    end

    // The oldest sample is read when a beat is taken and overwritten in the following cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_reg <= mem[idx_reg];
        end
        if (state_reg == S_READ)
        begin
            mem[idx_reg] <= sample_reg;
        end
    end

    `ASSERT_IMPLIES(a_fill_in_window, clk, rst_n, 1'b1, fill_reg <= window_reg)
    `ASSERT_IMPLIES(a_index_in_window, clk, rst_n, 1'b1, WIN_W'(idx_reg) < window_reg)
    `ASSERT_NEXT(a_accept_starts_read, clk, rst_n, accept, state_reg == S_READ)
    `ASSERT_IMPLIES(a_window_nonzero, clk, rst_n, 1'b1, window_reg != '0)

endmodule

FILE: sim/swr_rms_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sliding window RMS checker
// Watches the sample and result channels and the window size writes. It keeps
// its own copy of the window and the running sum of squares, and compares
// every result beat with the oldest predicted RMS value.
// ---------------------------------------------------------------------------
module swr_rms_checker #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int CFG_W       = $clog2(MAX_WINDOW + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    swr_sample_if            samples,
    swr_rms_if               results,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output int               mismatches,
    output int               outstanding
);
    import swr_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    sample_t     history [MAX_WINDOW];
    int unsigned win_len;
    int unsigned fill_cnt;
    int unsigned head_idx;
    logic [63:0] sq_sum;
    rms_t        rms_expected_q [$];
    int          err_count;

    function automatic logic [63:0] square_of_sample(sample_t s);
        longint w;
        w = s;
        return w * w;
    endfunction

    function automatic rms_t floor_root(logic [63:0] v);
        logic [16:0] root;
        logic [16:0] trial;
        logic [63:0] trial_sq;
        root = '0;
        for (int b = 16; b >= 0; b--)
        begin
            trial    = root | (17'd1 << b);
            trial_sq = 64'(trial) * 64'(trial);
            if (trial_sq <= v)
            begin
                root = trial;
            end
        end
        return root[RMS_W-1:0];
    endfunction

    function automatic void clear_window();
        foreach (history[i])
        begin
            history[i] = '0;
        end
        head_idx = 0;
        fill_cnt = 0;
        sq_sum   = '0;
    endfunction

    function automatic rms_t next_window_rms(sample_t s);
        int unsigned idx;
        logic [63:0] mean;
        idx = head_idx;
        if (fill_cnt >= win_len)
        begin
            sq_sum = sq_sum - square_of_sample(history[idx]);
        end
        else
        begin
            fill_cnt++;
        end
        history[idx] = s;
        sq_sum       = sq_sum + square_of_sample(s);
        mean         = sq_sum / 64'(fill_cnt);
        head_idx     = (idx + 1) % win_len;
        return floor_root(mean);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned new_len;
        rms_t        got;
        rms_t        want;
        if (!rst_n)
        begin
            win_len = MAX_WINDOW;
            clear_window();
            rms_expected_q.delete();
            err_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                new_len = cfg_wr_data;
                if (new_len < 1)
                begin
                    new_len = 1;
                end
                if (new_len > MAX_WINDOW)
                begin
                    new_len = MAX_WINDOW;
                end
                win_len = new_len;
                clear_window();
            end
            if (samples.valid && samples.ready)
            begin
                rms_expected_q.push_back(next_window_rms(samples.sample));
            end
            if (results.valid && results.ready)
            begin
                got = results.rms_value;
                if (rms_expected_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: rms_value beat with nothing pending: expected none, got %0d",
                             $time, got);
                end
                else
                begin
                    want = rms_expected_q.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        $display("%0t: rms_value mismatch: expected %0d, got %0d",
                                 $time, want, got);
                    end
                end
            end
        end
        mismatches  <= err_count;
        outstanding <= rms_expected_q.size();
    end

endmodule

FILE: sim/sliding_window_rms_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sliding window RMS testbench
// Drives sample beats through a directed opening and then random phases over
// many window sizes, with the sender and the receiver idling at various
// rates. A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module sliding_window_rms_tb;

    import swr_pkg::*;

    localparam int MAX_WINDOW   = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int CFG_W        = $clog2(MAX_WINDOW + 1);
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 4000;
    localparam int NO_WRITE     = -1;
    localparam int PHASE_ITEMS  = 4;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
    typedef enum {PAT_FULL, PAT_MIX, PAT_MOST_NEG} sample_pattern_e;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t DIRECTED_WIDE [9] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001,
                                              16'shffff, 16'sh5555, 16'shaaaa, 16'sh0064,
                                              16'shff9c};
    localparam sample_t DIRECTED_UNIT [5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                                              16'sh0001};
    localparam sample_t DIRECTED_PAIR [5] = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000,
                                              16'sh0000};
    localparam int SMALL_WINDOWS [12] = '{1, 3, 7, 1025, 2, 16, 5, 0, 33, 64, 1024, 11};

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               mismatches;
    int               outstanding;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               quiet_cycles;

    swr_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    swr_rms_if                                 rms_ch ();

    sliding_window_rms #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .results     (rms_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    swr_rms_checker #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .results     (rms_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        rms_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) || (rms_ch.valid && rms_ch.ready)
            || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idle(idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND:
            begin
                send_idle_pct  = 88;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 88;
            end
            default:
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    function automatic sample_t pick_sample(sample_pattern_e pattern);
        sample_t s;
        s = sample_t'($urandom);
        if (pattern == PAT_MOST_NEG)
        begin
            s = 16'sh8000;
        end
        else if (pattern == PAT_MIX)
        begin
            case ($urandom_range(7))
                0: s = 16'sh8000;
                1: s = 16'sh7fff;
                2: s = 16'sh0000;
                3: s = 16'shffff;
                4: s = 16'sh0001;
                default: ;
            endcase
        end
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
    endtask

    // The block is only written once every pending result has left it.
    task automatic write_window(int unsigned value);
        sample_ch.valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(int cfg, int items, sample_pattern_e pattern, idle_mode_e mode);
        if (cfg != NO_WRITE)
        begin
            write_window(cfg);
        end
        set_idle(mode);
        repeat (items) send_sample(pick_sample(pattern));
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        rms_ch.ready     = 1'b0;
        quiet_cycles     = 0;
        set_idle(IDLE_NONE);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_WIDE[i])
        begin
            send_sample(DIRECTED_WIDE[i]);
        end
        write_window(0);
        foreach (DIRECTED_UNIT[i])
        begin
            send_sample(DIRECTED_UNIT[i]);
        end
        write_window(2);
        foreach (DIRECTED_PAIR[i])
        begin
            send_sample(DIRECTED_PAIR[i]);
        end

        for (int p = 0; p < 12; p++)
        begin
            run_phase(SMALL_WINDOWS[p], PHASE_ITEMS, (p % 2 == 0) ? PAT_MIX : PAT_FULL,
                      idle_mode_e'(p % 4));
        end

        // A full window of the most negative sample drives the sum to its top bit.
        run_phase(2047, MAX_WINDOW, PAT_MOST_NEG, IDLE_NONE);
        run_phase(NO_WRITE, 20, PAT_MIX, IDLE_BOTH);
        run_phase($urandom_range(1, 40), 16, PAT_FULL, IDLE_RECV);

        sample_ch.valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
